/* hw/rtl/fsfl_pkg.sv */
// ----------------------------------------------------------------------------
// Free-list slot allocator package
// Operation, status and register codes and the sequencer state type.
// ----------------------------------------------------------------------------
package fsfl_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_BUILD = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POOL_BASE  = 2'd0;
  localparam logic [1:0] CFG_SLOT_BYTES = 2'd1;
  localparam logic [1:0] CFG_SLOTS_REQ  = 2'd2;
  localparam logic [1:0] CFG_ALIGN      = 2'd3;

  // Field widths fixed by the interface.
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned REQ_W     = 8;
  localparam int unsigned IDX_OUT_W = 7;
  localparam int unsigned CNT_OUT_W = 8;
  localparam int unsigned BLK_W     = SIZE_W + REQ_W;

  // The shared divider retires one quotient bit per cycle.
  localparam int unsigned DIV_STEPS  = ADDR_W;
  localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DIV_REM  = 10'b00_0000_0010,
    S_BLD_CNT  = 10'b00_0000_0100,
    S_DIV_CNT  = 10'b00_0000_1000,
    S_BLD_SAT  = 10'b00_0001_0000,
    S_BLD_LINK = 10'b00_0010_0000,
    S_DIV_IDX  = 10'b00_0100_0000,
    S_FREE_CHK = 10'b00_1000_0000,
    S_ALLOC    = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } fsfl_state_e;

endpackage

/* hw/rtl/fixed_slot_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// Fixed-slot free-list allocator
// An item is taken only in the idle state and the input stalls until its
// result moves to the output register, so one item is in flight at a time.
// Free and build wait on the bit-serial divider, allocate on the link memory
// read, and an item answered by status alone goes straight to the output.
// Reset: pool not built, list empty, configuration at its reset values. The
// link memory is not cleared; build writes every link before it is read.
// ----------------------------------------------------------------------------
// A slot pool with a last-in-first-out free list kept in a link memory.
//
// A build item first divides the pool base by the alignment to find the
// misalignment; if there is one, it pads the head up to the next aligned
// address and trims the raw block by one alignment unit in all. It then
// divides the rest by the slot size to get the usable slot count, saturated
// at MAX_SLOTS. A sweep then writes one link per cycle, slot n-1 at the head.
//
// Allocate pops the list head. The link of the head is read from the memory
// at the edge where the item is accepted, so the following cycle can form the
// slot address with one small multiply and add and move the head on.
//
// Free subtracts the aligned head from the address and divides the offset by
// the slot size. A quotient at or above the usable count is a foreign address
// and is ignored, as is address zero; otherwise the slot is pushed onto the list.
//
// All three divisions share one restoring divider that takes a 32-bit
// dividend and a 13-bit divisor and produces one quotient bit per cycle.
//
// Finished results sit in a result register and move to the output register
// when it is free, so a result waiting on a stalled consumer never blocks the
// arithmetic of the item.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator
  import fsfl_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,

  // Input item channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           in_opcode_i,
  input  logic [ADDR_W-1:0]    in_free_address_i,

  // Result item channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ADDR_W-1:0]    out_slot_address_o,
  output logic [IDX_OUT_W-1:0] out_slot_index_o,
  output logic [1:0]           out_status_o,
  output logic [CNT_OUT_W-1:0] out_usable_slots_o
);

  // Slot index width, and count width which also holds the null marker.
  localparam int unsigned AW = $clog2(MAX_SLOTS);
  localparam int unsigned LW = $clog2(MAX_SLOTS + 1);
  localparam logic [LW-1:0] SLOT_CAP  = LW'(MAX_SLOTS);
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_SLOTS);

  fsfl_state_e state_q, state_d;

  // Configuration registers.
  logic [ADDR_W-1:0] pool_base_q;
  logic [SIZE_W-1:0] slot_bytes_q;
  logic [REQ_W-1:0]  slots_req_q;
  logic [SIZE_W-1:0] align_bytes_q;

  // Pool state.
  logic              built_q, built_d;
  logic [LW-1:0]     head_q, head_d;
  logic [LW-1:0]     count_q, count_d;
  logic [ADDR_W-1:0] ahead_q, ahead_d;

  // Shared divider: dividend shifts out at the top while quotient bits
  // shift in at the bottom.
  logic [ADDR_W-1:0]     dvd_q, dvd_d;
  logic [SIZE_W-1:0]     rem_q, rem_d;
  logic [SIZE_W-1:0]     dvs_q, dvs_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic [SIZE_W:0]       div_trial;
  logic [SIZE_W:0]       div_diff;
  logic                  div_ge;
  logic                  div_last;

  // Build and sweep working registers.
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [LW-1:0]    sweep_q, sweep_d;

  // Result waiting for the output register.
  logic [ADDR_W-1:0]    res_addr_q, res_addr_d;
  logic [IDX_OUT_W-1:0] res_idx_q, res_idx_d;
  logic [1:0]           res_status_q, res_status_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic [ADDR_W-1:0]    out_addr_q;
  logic [IDX_OUT_W-1:0] out_idx_q;
  logic [1:0]           out_status_q;
  logic [CNT_OUT_W-1:0] out_usable_q;

  // Link memory ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [LW-1:0] ram_rdata;

  // Derived values.
  logic [SIZE_W-1:0]    size_eff;
  logic [SIZE_W-1:0]    align_eff;
  logic [SIZE_W-1:0]    trim;
  logic [SIZE_W-1:0]    pad;
  logic [LW+SIZE_W-1:0] alloc_prod;
  logic [ADDR_W-1:0]    alloc_addr;
  logic [ADDR_W-1:0]    free_off;
  logic                 cfg_we;

  // A register value of zero acts as one.
  assign size_eff  = (slot_bytes_q == '0) ? SIZE_W'(1) : slot_bytes_q;
  assign align_eff = (align_bytes_q == '0) ? SIZE_W'(1) : align_bytes_q;

  // One restoring step of the shared divider.
  assign div_trial = {rem_q, dvd_q[ADDR_W-1]};
  assign div_ge    = (div_trial >= {1'b0, dvs_q});
  assign div_diff  = div_trial - {1'b0, dvs_q};
  assign div_last  = (step_q == DIV_STEP_W'(DIV_STEPS - 1));

  // With the base remainder in rem_q and the alignment in dvs_q, the head
  // pad and the tail trim remove exactly one alignment unit, or none if aligned.
  assign pad  = (rem_q != '0) ? (dvs_q - rem_q) : '0;
  assign trim = (rem_q != '0) ? dvs_q : '0;

  assign alloc_prod = head_q * size_eff;
  assign alloc_addr = ahead_q + ADDR_W'(alloc_prod);
  assign free_off   = in_free_address_i - ahead_q;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    built_d      = built_q;
    head_d       = head_q;
    count_d      = count_q;
    ahead_d      = ahead_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    dvs_d        = dvs_q;
    step_d       = step_q;
    blk_d        = blk_q;
    sweep_d      = sweep_q;
    res_addr_d   = res_addr_q;
    res_idx_d    = res_idx_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = sweep_q[AW-1:0];
    ram_wdata    = head_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_addr_d   = '0;
          res_idx_d    = '0;
          res_status_d = ST_OK;
          state_d      = S_OUT;
          case (in_opcode_i)
            OP_ALLOC: begin
              if (!built_q) begin
                res_status_d = ST_NOT_BUILT;
              end else if (head_q >= count_q) begin
                res_status_d = ST_EMPTY;
              end else begin
                // The link of the head is captured by the memory this edge.
                state_d = S_ALLOC;
              end
            end
            OP_FREE: begin
              if (!built_q) begin
                res_status_d = ST_NOT_BUILT;
              end else if (in_free_address_i == '0) begin
                res_status_d = ST_IGNORED;
              end else begin
                dvd_d   = free_off;
                rem_d   = '0;
                dvs_d   = size_eff;
                step_d  = '0;
                state_d = S_DIV_IDX;
              end
            end
            OP_BUILD: begin
              dvd_d   = pool_base_q;
              rem_d   = '0;
              dvs_d   = align_eff;
              step_d  = '0;
              blk_d   = size_eff * slots_req_q;
              state_d = S_DIV_REM;
            end
            default: begin
              // Reserved code: plain success with nothing changed.
            end
          endcase
        end
      end

      S_DIV_REM, S_DIV_CNT, S_DIV_IDX: begin
        dvd_d  = {dvd_q[ADDR_W-2:0], div_ge};
        rem_d  = div_ge ? div_diff[SIZE_W-1:0] : div_trial[SIZE_W-1:0];
        step_d = step_q + DIV_STEP_W'(1);
        if (div_last) begin
          case (state_q)
            S_DIV_REM: state_d = S_BLD_CNT;
            S_DIV_CNT: state_d = S_BLD_SAT;
            default:   state_d = S_FREE_CHK;
          endcase
        end
      end

      S_BLD_CNT: begin
        ahead_d = pool_base_q + ADDR_W'(pad);
        if (blk_q >= BLK_W'(trim)) begin
          dvd_d   = ADDR_W'(blk_q - BLK_W'(trim));
          rem_d   = '0;
          dvs_d   = size_eff;
          step_d  = '0;
          state_d = S_DIV_CNT;
        end else begin
          // Block too small for the trims: no usable slots.
          dvd_d   = '0;
          state_d = S_BLD_SAT;
        end
      end

      S_BLD_SAT: begin
        count_d = (dvd_q >= ADDR_W'(MAX_SLOTS)) ? SLOT_CAP : dvd_q[LW-1:0];
        head_d  = NULL_LINK;
        sweep_d = '0;
        state_d = S_BLD_LINK;
      end

      S_BLD_LINK: begin
        if (sweep_q < count_q) begin
          ram_we    = 1'b1;
          ram_waddr = sweep_q[AW-1:0];
          ram_wdata = (sweep_q == '0) ? NULL_LINK : (sweep_q - LW'(1));
          sweep_d   = sweep_q + LW'(1);
        end else begin
          head_d  = (count_q == '0) ? NULL_LINK : (count_q - LW'(1));
          built_d = 1'b1;
          state_d = S_OUT;
        end
      end

      S_FREE_CHK: begin
        if (dvd_q >= ADDR_W'(count_q)) begin
          res_status_d = ST_IGNORED;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = dvd_q[AW-1:0];
          ram_wdata = head_q;
          head_d    = dvd_q[LW-1:0];
          res_idx_d = IDX_OUT_W'(dvd_q[LW-1:0]);
        end
        state_d = S_OUT;
      end

      S_ALLOC: begin
        res_addr_d = alloc_addr;
        res_idx_d  = IDX_OUT_W'(head_q);
        head_d     = ram_rdata;
        state_d    = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_load    = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      built_q       <= 1'b0;
      head_q        <= NULL_LINK;
      count_q       <= '0;
      ahead_q       <= '0;
      out_valid_q   <= 1'b0;
      pool_base_q   <= '0;
      slot_bytes_q  <= SIZE_W'(8);
      slots_req_q   <= REQ_W'(128);
      align_bytes_q <= SIZE_W'(8);
    end else begin
      state_q     <= state_d;
      built_q     <= built_d;
      head_q      <= head_d;
      count_q     <= count_d;
      ahead_q     <= ahead_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        case (cfg_index_i)
          CFG_POOL_BASE:  pool_base_q   <= cfg_data_i;
          CFG_SLOT_BYTES: slot_bytes_q  <= cfg_data_i[SIZE_W-1:0];
          CFG_SLOTS_REQ:  slots_req_q   <= cfg_data_i[REQ_W-1:0];
          CFG_ALIGN:      align_bytes_q <= cfg_data_i[SIZE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    dvs_q        <= dvs_d;
    step_q       <= step_d;
    blk_q        <= blk_d;
    sweep_q      <= sweep_d;
    res_addr_q   <= res_addr_d;
    res_idx_q    <= res_idx_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_addr_q   <= res_addr_q;
      out_idx_q    <= res_idx_q;
      out_status_q <= res_status_q;
      out_usable_q <= CNT_OUT_W'(count_q);
    end
  end

  fsfl_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o        = out_valid_q;
  assign out_slot_address_o = out_addr_q;
  assign out_slot_index_o   = out_idx_q;
  assign out_status_o       = out_status_q;
  assign out_usable_slots_o = out_usable_q;

endmodule

/* hw/rtl/fsfl_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fsfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
